// ===== sv/sete_pkg.sv =====
// ----------------------------------------------------------------------------
// sete_pkg
// Shared constants and types of the sync edge timestamp qualifier.
// ----------------------------------------------------------------------------
package sete_pkg;

  localparam int unsigned FifoDepthDefault = 128;

  localparam logic [31:0] MinPeriodReset     = 32'd909;
  localparam logic [31:0] HoldoffPeriodReset = 32'd100000;

  localparam logic [1:0] CmdCapture = 2'd0;
  localparam logic [1:0] CmdTick    = 2'd1;
  localparam logic [1:0] CmdPop     = 2'd2;
  localparam logic [1:0] CmdStatus  = 2'd3;

  localparam logic RegMinPeriod     = 1'b0;
  localparam logic RegHoldoffPeriod = 1'b1;

  localparam int unsigned EntryWidth = 65;

  typedef struct packed {
    logic        in_holdoff;
    logic [31:0] lost_edges;
    logic        error_seen;
    logic        pop_valid;
    logic        edge_phase;
    logic [63:0] edge_ticks;
  } result_t;

endpackage

// ===== sv/sete_ram.sv =====
// ----------------------------------------------------------------------------
// sete_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sete_ram #(
  parameter int unsigned Width = sete_pkg::EntryWidth,
  parameter int unsigned Depth = sete_pkg::FifoDepthDefault,
  localparam int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sync_edge_timestamp_qualifier.sv =====
// ----------------------------------------------------------------------------
// sync_edge_timestamp_qualifier
// Qualifies and timestamps sync edges and queues them in an edge FIFO.
// ----------------------------------------------------------------------------
// Input beats carry a command in s_axis_tuser (capture, tick, pop, status)
// and a timestamp with an overrun flag in s_axis_tdata. Each input beat
// yields exactly one output beat on the master side, in order.
// The qualifier state sits in registers and is updated in the cycle a beat
// is accepted; the edge FIFO lives in a RAM whose registered read port
// returns popped entries in the cycle after the pop.
// The result of a beat passes the stage aligned with the RAM read data and
// then the output queue before it appears on m_axis.
// One beat is accepted every cycle while the receiver keeps up; the rate is
// set by the single update of the qualifier registers per cycle.
// A three-entry output queue absorbs results in flight; a stalled receiver
// costs nothing until queue and read stage hold three, then s_axis_tready drops.
// Configuration writes take effect at once; the user must make them while
// idle, which the block does not enforce. After reset the FIFO is empty, the
// error flag and lost count are clear, no holdoff is active and the first
// edge phase is expected. The RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module sync_edge_timestamp_qualifier #(
  parameter int unsigned FifoDepth = sete_pkg::FifoDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // Fields from bit 0: ticks[63:0], hw_overrun, zero fill.
  input  logic [71:0]   s_axis_tdata,
  // Fields from bit 0: cmd[1:0].
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // Fields from bit 0: edge_ticks[63:0], edge_phase, pop_valid, error_seen,
  // lost_edges[31:0], in_holdoff, zero fill.
  output logic [103:0]  m_axis_tdata
);

  localparam int unsigned AddrWidth = $clog2(FifoDepth);
  localparam int unsigned FillWidth = $clog2(FifoDepth + 1);
  localparam logic [AddrWidth-1:0] LastSlot  = AddrWidth'(FifoDepth - 1);
  localparam logic [FillWidth-1:0] FullCount = FillWidth'(FifoDepth);

  logic [31:0] min_gap_q, hold_len_q;
  logic        phase_q, phase_d;
  logic [63:0] last_first_q, last_first_d;
  logic [63:0] deadline_q, deadline_d;
  logic        error_q, error_d;
  logic [31:0] lost_q, lost_d;
  logic [AddrWidth-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FillWidth-1:0] fill_q, fill_d;

  logic        accept;
  logic [1:0]  cmd;
  logic [63:0] ticks;
  logic        overrun;
  logic        ram_we, ram_re;
  logic [sete_pkg::EntryWidth-1:0] ram_rdata;
  logic        res_err, res_lost_unused;
  logic [31:0] res_lost;
  logic        res_pop;
  logic [63:0] delta;
  logic        too_fast;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign cmd     = s_axis_tuser;
  assign ticks   = s_axis_tdata[63:0];
  assign overrun = s_axis_tdata[64];
  assign delta    = ticks - last_first_q;
  assign too_fast = delta < {32'd0, min_gap_q};
  assign res_lost_unused = 1'b0;

  always_comb begin
    phase_d      = phase_q;
    last_first_d = last_first_q;
    deadline_d   = deadline_q;
    error_d      = error_q;
    lost_d       = lost_q;
    wptr_d       = wptr_q;
    rptr_d       = rptr_q;
    fill_d       = fill_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    res_pop      = 1'b0;
    if (accept) begin
      unique case (cmd)
        sete_pkg::CmdCapture: begin
          if (deadline_q == 64'd0) begin
            if (overrun || (phase_q && too_fast)) begin
              error_d    = 1'b1;
              phase_d    = 1'b1;
              deadline_d = ticks + {32'd0, hold_len_q};
            end else begin
              if (phase_q) begin
                last_first_d = ticks;
              end
              if (fill_q < FullCount) begin
                ram_we = 1'b1;
                wptr_d = (wptr_q == LastSlot) ? '0 : wptr_q + 1'b1;
                fill_d = fill_q + 1'b1;
              end else if (lost_q != 32'hFFFF_FFFF) begin
                lost_d = lost_q + 32'd1;
              end
              phase_d = ~phase_q;
            end
          end
        end
        sete_pkg::CmdTick: begin
          if (deadline_q != 64'd0 && ticks >= deadline_q) begin
            deadline_d = 64'd0;
          end
        end
        sete_pkg::CmdPop: begin
          if (fill_q != '0) begin
            ram_re  = 1'b1;
            res_pop = 1'b1;
            rptr_d  = (rptr_q == LastSlot) ? '0 : rptr_q + 1'b1;
            fill_d  = fill_q - 1'b1;
          end
        end
        sete_pkg::CmdStatus: begin
          error_d = 1'b0;
          lost_d  = 32'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // Status reports the values before clearing; everything else after the beat.
  assign res_err  = (cmd == sete_pkg::CmdStatus) ? error_q : error_d;
  assign res_lost = (cmd == sete_pkg::CmdStatus) ? lost_q : lost_d | {31'd0, res_lost_unused};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q    <= sete_pkg::MinPeriodReset;
      hold_len_q   <= sete_pkg::HoldoffPeriodReset;
      phase_q      <= 1'b1;
      last_first_q <= 64'd0;
      deadline_q   <= 64'd0;
      error_q      <= 1'b0;
      lost_q       <= 32'd0;
      wptr_q       <= '0;
      rptr_q       <= '0;
      fill_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sete_pkg::RegMinPeriod:     min_gap_q  <= cfg_wdata_i;
          sete_pkg::RegHoldoffPeriod: hold_len_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      phase_q      <= phase_d;
      last_first_q <= last_first_d;
      deadline_q   <= deadline_d;
      error_q      <= error_d;
      lost_q       <= lost_d;
      wptr_q       <= wptr_d;
      rptr_q       <= rptr_d;
      fill_q       <= fill_d;
    end
  end

  sete_ram #(
    .Width (sete_pkg::EntryWidth),
    .Depth (FifoDepth)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i ({phase_q, ticks}),
    .re_i    (ram_re),
    .raddr_i (rptr_q),
    .rdata_o (ram_rdata)
  );

  // Stage aligned with the RAM read data.
  logic        s1_valid_q;
  logic        s1_pop_q, s1_err_q, s1_hold_q;
  logic [31:0] s1_lost_q;
  sete_pkg::result_t s1_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pop_q  <= res_pop;
      s1_err_q  <= res_err;
      s1_lost_q <= res_lost;
      s1_hold_q <= deadline_d != 64'd0;
    end
  end

  always_comb begin
    s1_res.edge_ticks = s1_pop_q ? ram_rdata[63:0] : 64'd0;
    s1_res.edge_phase = s1_pop_q ? ram_rdata[64] : 1'b0;
    s1_res.pop_valid  = s1_pop_q;
    s1_res.error_seen = s1_err_q;
    s1_res.lost_edges = s1_lost_q;
    s1_res.in_holdoff = s1_hold_q;
  end

  // Three-entry output queue.
  sete_pkg::result_t oq_q [3];
  logic [1:0] oq_head_q, oq_tail_q, oq_cnt_q;
  logic       oq_pop;
  logic [2:0] in_flight;

  assign oq_pop        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = oq_cnt_q != 2'd0;
  assign m_axis_tdata  = {4'd0, oq_q[oq_head_q]};
  assign in_flight     = {1'b0, oq_cnt_q} + {2'd0, s1_valid_q};
  assign s_axis_tready = in_flight <= 3'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_head_q <= 2'd0;
      oq_tail_q <= 2'd0;
      oq_cnt_q  <= 2'd0;
    end else begin
      if (s1_valid_q) begin
        oq_tail_q <= (oq_tail_q == 2'd2) ? 2'd0 : oq_tail_q + 2'd1;
      end
      if (oq_pop) begin
        oq_head_q <= (oq_head_q == 2'd2) ? 2'd0 : oq_head_q + 2'd1;
      end
      oq_cnt_q <= oq_cnt_q + {1'b0, s1_valid_q} - {1'b0, oq_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      oq_q[oq_tail_q] <= s1_res;
    end
  end

endmodule
